FILE: hw/rtl/irts_pkg.sv
// Package for the I2C register transfer sequencer.
// Holds the item structs, operation codes, start kinds and phase flag bits.
// No dependencies.
`default_nettype none

package irts_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_READY = 2'd1,
    OP_NACK  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    START_NONE = 2'd0,
    START_TX   = 2'd1,
    START_RX   = 2'd2,
    START_RSVD = 2'd3
  } start_kind_t;

  // Phase flag bits.
  localparam logic [3:0] PH_READ   = 4'h1;
  localparam logic [3:0] PH_WIDE   = 4'h2;
  localparam logic [3:0] PH_LOWADR = 4'h4;
  localparam logic [3:0] PH_REPST  = 4'h8;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  device_id;
    logic [7:0]  transfer_code;
    logic [15:0] mem_address;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    start_kind_t start_kind;
    logic [6:0]  slave_address;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        store_valid;
    logic [7:0]  store_byte;
    logic [6:0]  byte_index;
    logic        stop_request;
    logic        done_res;
    logic        nack_error;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/irts_core.sv
// Transfer state registers and the next-state and result logic for one item.
// Depends on irts_pkg.
`default_nettype none

module irts_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_en,
  input  wire irts_pkg::in_item_t item,
  output irts_pkg::out_item_t     result
);
  import irts_pkg::*;

  logic [3:0]  phase_flags;
  logic [3:0]  phase_flags_next;
  logic [7:0]  bytes_left;
  logic [7:0]  bytes_left_next;
  logic [15:0] target_address;
  logic [15:0] target_address_next;
  logic [6:0]  buffer_position;
  logic [6:0]  buffer_position_next;
  logic [6:0]  slave_latch;
  logic [6:0]  slave_latch_next;
  logic [3:0]  phase_low_cleared;

  always_comb begin
    phase_flags_next     = phase_flags;
    bytes_left_next      = bytes_left;
    target_address_next  = target_address;
    buffer_position_next = buffer_position;
    slave_latch_next     = slave_latch;
    phase_low_cleared    = phase_flags & ~PH_LOWADR;
    result               = '0;
    result.start_kind    = START_NONE;

    unique case (item.operation)
      OP_START: begin
        phase_flags_next = PH_LOWADR
                         | (item.transfer_code[0] ? PH_WIDE : 4'h0)
                         | (item.device_id[0] ? PH_READ : 4'h0);
        bytes_left_next      = {1'b0, item.transfer_code[7:1]} + 8'd1;
        target_address_next  = item.mem_address;
        buffer_position_next = '0;
        slave_latch_next     = item.device_id[7:1];
        result.start_kind    = START_TX;
        result.slave_address = item.device_id[7:1];
      end
      OP_READY: begin
        priority if (phase_flags == 4'h0) begin
          // Write data phase; also the idle phase before any start.
          if (bytes_left != 8'd0) begin
            result.send_valid    = 1'b1;
            result.send_byte     = item.tx_byte;
            result.byte_index    = buffer_position;
            buffer_position_next = buffer_position + 7'd1;
            bytes_left_next      = bytes_left - 8'd1;
          end else begin
            result.stop_request = 1'b1;
            result.done_res     = 1'b1;
          end
        end else if (phase_flags == PH_READ) begin
          if (bytes_left != 8'd0) begin
            result.store_valid   = 1'b1;
            result.store_byte    = item.rx_byte;
            result.byte_index    = buffer_position;
            buffer_position_next = buffer_position + 7'd1;
            bytes_left_next      = bytes_left - 8'd1;
            // Stop is requested ahead of the last byte.
            result.stop_request  = (bytes_left == 8'd2);
            result.done_res      = (bytes_left == 8'd1);
          end
        end else if ((phase_flags & PH_WIDE) != 4'h0) begin
          result.send_valid = 1'b1;
          result.send_byte  = target_address[15:8];
          phase_flags_next  = phase_flags & ~PH_WIDE;
        end else if ((phase_flags & PH_LOWADR) != 4'h0) begin
          result.send_valid = 1'b1;
          result.send_byte  = target_address[7:0];
          phase_flags_next  = (phase_low_cleared != 4'h0) ?
                              (phase_low_cleared | PH_REPST) : phase_low_cleared;
        end else begin
          // Only the repeated start remains pending.
          phase_flags_next     = phase_flags & ~PH_REPST;
          result.start_kind    = START_RX;
          result.slave_address = slave_latch;
          // A single-byte read stops right after its one byte.
          result.stop_request  = (bytes_left == 8'd1);
        end
      end
      OP_NACK: begin
        result.stop_request = 1'b1;
        result.nack_error   = 1'b1;
      end
      OP_RSVD: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_flags     <= '0;
      bytes_left      <= '0;
      target_address  <= '0;
      buffer_position <= '0;
      slave_latch     <= '0;
    end else if (step_en) begin
      phase_flags     <= phase_flags_next;
      bytes_left      <= bytes_left_next;
      target_address  <= target_address_next;
      buffer_position <= buffer_position_next;
      slave_latch     <= slave_latch_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/irts_out_reg.sv
// Result register of the sequencer with its valid/ready handshake.
// Depends on irts_pkg.
`default_nettype none

module irts_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire irts_pkg::out_item_t load_item,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output irts_pkg::out_item_t      out_item
);
  import irts_pkg::*;

  // A new result may replace the held one in the cycle it is taken.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_register_transfer_sequencer.sv
// Top level of the I2C register transfer sequencer: input register, core, result register.
// Depends on irts_pkg, irts_core and irts_out_reg.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   in_item  (irts_pkg::in_item_t)
//   output   out_valid / out_ready out_item (irts_pkg::out_item_t)
//
// Each item gives exactly one result, which passes through the input register
// and then the result register around the core's combinational result logic;
// one item is taken every cycle while the output is not stalled.
// Reset clears the transfer state to zero and empties both registers.
// A stalled output holds its result; the input register fills and then
// in_ready drops until the result is taken.
`default_nettype none

module i2c_register_transfer_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire irts_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output irts_pkg::out_item_t     out_item
);
  import irts_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  out_item_t step_result;
  logic      can_load;
  logic      advance;

  assign advance  = stage_valid && can_load;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  irts_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (stage_item),
    .result  (step_result)
  );

  irts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_item (step_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
